// ===== sv/nket_pkg.sv =====
// Shared types and codes for the name-keyed entry table.
// Used by nket_cell and name_keyed_entry_table; depends on nothing else.
package nket_pkg;

	localparam int unsigned OP_W      = 2;
	localparam int unsigned HEAD_W    = 64;
	localparam int unsigned TAIL_W    = 8;
	localparam int unsigned SECT_W    = 10;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned IDX_OUT_W = 4;
	localparam int unsigned S_DATA_W  = 88;
	localparam int unsigned M_DATA_W  = 16;

	typedef enum logic [OP_W-1:0] {
		OP_FIND   = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2
	} nket_op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_PRESENT   = 2'd2,
		ST_FULL      = 2'd3
	} nket_status_t;

	// request that walks the cell row
	typedef struct packed {
		nket_op_t            op;
		logic [HEAD_W-1:0]   head;
		logic [TAIL_W-1:0]   tail;
		logic [SECT_W-1:0]   sector;
		logic                dir;
	} nket_key_t;

	// scan result gathered along the row
	typedef struct packed {
		logic                hit;
		logic                free;
		logic [SECT_W-1:0]   sector;
		logic                dir;
	} nket_scan_t;

	// write command broadcast to the cells
	typedef struct packed {
		logic                set;
		logic                clr;
		logic [HEAD_W-1:0]   head;
		logic [TAIL_W-1:0]   tail;
		logic [SECT_W-1:0]   sector;
		logic                dir;
	} nket_wr_t;

endpackage

// ===== sv/nket_cell.sv =====
// One table slot: holds an entry, matches the passing request against it
// and hands the request and scan result on to the next cell. Uses nket_pkg.
module nket_cell #(
	parameter int unsigned IDX_W    = 4,
	parameter int unsigned CELL_IDX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nket_pkg::nket_key_t    key_in,
	input  nket_pkg::nket_scan_t   scan_in,
	input  logic [IDX_W-1:0]       hit_idx_in,
	input  logic [IDX_W-1:0]       free_idx_in,
	output nket_pkg::nket_key_t    key_out,
	output nket_pkg::nket_scan_t   scan_out,
	output logic [IDX_W-1:0]       hit_idx_out,
	output logic [IDX_W-1:0]       free_idx_out,
	input  nket_pkg::nket_wr_t     wr,
	input  logic [IDX_W-1:0]       wr_idx,
	output logic                   slot_valid
);
	import nket_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                valid_q;
	logic [HEAD_W-1:0]   name_q;
	logic [TAIL_W-1:0]   tail_q;
	logic [SECT_W-1:0]   sector_q;
	logic                dir_q;
	nket_key_t           key_q;
	nket_scan_t          scan_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                match;
	logic                take_hit;
	logic                take_free;
	logic                wr_sel;

	assign match     = valid_q && (key_in.head == name_q) && (key_in.tail == tail_q);
	assign take_hit  = match && !scan_in.hit;
	assign take_free = !valid_q && !scan_in.free;
	assign wr_sel    = (wr_idx == MY_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_sel && wr.set) begin
			valid_q <= 1'b1;
		end else if (wr_sel && wr.clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel && wr.set) begin
			name_q   <= wr.head;
			tail_q   <= wr.tail;
			sector_q <= wr.sector;
			dir_q    <= wr.dir;
		end
	end

	// advance the request one cell
	always_ff @(posedge clk) begin
		key_q           <= key_in;
		scan_q.hit      <= scan_in.hit || match;
		scan_q.free     <= scan_in.free || !valid_q;
		scan_q.sector   <= take_hit ? sector_q : scan_in.sector;
		scan_q.dir      <= take_hit ? dir_q : scan_in.dir;
		hit_idx_q       <= take_hit ? MY_IDX : hit_idx_in;
		free_idx_q      <= take_free ? MY_IDX : free_idx_in;
	end

	assign key_out      = key_q;
	assign scan_out     = scan_q;
	assign hit_idx_out  = hit_idx_q;
	assign free_idx_out = free_idx_q;
	assign slot_valid   = valid_q;

endmodule

// ===== sv/name_keyed_entry_table.sv =====
// Name-keyed entry table: find, add and remove over a row of slot cells.
// Each accepted item is registered, then its request walks through the
// TABLE_DEPTH cells, one cell per cycle, and the result is registered at
// the output; no new item is accepted until that result is loaded there.
// Reset clears every slot valid mark at once; no clearing pass.
// Uses nket_pkg and nket_cell.
module name_keyed_entry_table #(
	parameter int unsigned TABLE_DEPTH  = 16,
	parameter int unsigned NAME_BYTES   = 9,
	parameter int unsigned SECTOR_COUNT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// name_head[63:0], name_tail[71:64], sector[81:72], make_directory[82]
	input  logic [nket_pkg::S_DATA_W-1:0]     s_tdata,
	// operation[1:0]
	input  logic [nket_pkg::OP_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// entry_index[3:0], found_sector[13:4], found_is_directory[14]
	output logic [nket_pkg::M_DATA_W-1:0]     m_tdata,
	// status[1:0]
	output logic [nket_pkg::STAT_W-1:0]       m_tuser
);
	import nket_pkg::*;

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [HEAD_W-1:0] HEAD_MASK = (NAME_BYTES >= 8) ? {HEAD_W{1'b1}} :
		((64'd1 << (8 * NAME_BYTES)) - 64'd1);
	localparam logic [TAIL_W-1:0] TAIL_MASK = (NAME_BYTES >= 9) ? {TAIL_W{1'b1}} : '0;
	localparam logic [SECT_W-1:0] SECT_MAX  = SECT_W'(SECTOR_COUNT - 1);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    cnt_q;
	nket_key_t           tok_q;
	logic                out_valid_q;
	nket_status_t        out_status_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic [SECT_W-1:0]   out_sec_q;
	logic                out_dir_q;

	nket_key_t           key_c   [TABLE_DEPTH+1];
	nket_scan_t          scan_c  [TABLE_DEPTH+1];
	logic [IDX_W-1:0]    hidx_c  [TABLE_DEPTH+1];
	logic [IDX_W-1:0]    fidx_c  [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] slot_valid;

	logic                accept;
	logic                out_load;
	logic [SECT_W-1:0]   sec_in;
	logic [SECT_W-1:0]   sec_clamped;
	nket_status_t        res_status;
	logic [IDX_W-1:0]    res_idx;
	logic [31:0]         res_idx_wide;
	logic [SECT_W-1:0]   res_sec;
	logic                res_dir;
	nket_wr_t            wr;
	logic [IDX_W-1:0]    wr_idx;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);

	assign sec_in      = s_tdata[81:72];
	assign sec_clamped = (32'(sec_in) >= 32'(SECTOR_COUNT)) ? SECT_MAX : sec_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
					end
				end
				S_SCAN: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= S_DONE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_q.op     <= nket_op_t'(s_tuser);
			tok_q.head   <= s_tdata[63:0] & HEAD_MASK;
			tok_q.tail   <= s_tdata[71:64] & TAIL_MASK;
			tok_q.sector <= sec_clamped;
			tok_q.dir    <= s_tdata[82];
		end
	end

	assign key_c[0]  = tok_q;
	assign scan_c[0] = '0;
	assign hidx_c[0] = '0;
	assign fidx_c[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		nket_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.key_in       (key_c[i]),
			.scan_in      (scan_c[i]),
			.hit_idx_in   (hidx_c[i]),
			.free_idx_in  (fidx_c[i]),
			.key_out      (key_c[i+1]),
			.scan_out     (scan_c[i+1]),
			.hit_idx_out  (hidx_c[i+1]),
			.free_idx_out (fidx_c[i+1]),
			.wr           (wr),
			.wr_idx       (wr_idx),
			.slot_valid   (slot_valid[i])
		);
	end

	always_comb begin
		res_status = ST_NOT_FOUND;
		res_idx    = '0;
		res_sec    = '0;
		res_dir    = 1'b0;
		wr.set     = 1'b0;
		wr.clr     = 1'b0;
		wr.head    = key_c[TABLE_DEPTH].head;
		wr.tail    = key_c[TABLE_DEPTH].tail;
		wr.sector  = key_c[TABLE_DEPTH].sector;
		wr.dir     = key_c[TABLE_DEPTH].dir;
		wr_idx     = '0;
		case (key_c[TABLE_DEPTH].op)
			OP_FIND: begin
				if (scan_c[TABLE_DEPTH].hit) begin
					res_status = ST_OK;
					res_idx    = hidx_c[TABLE_DEPTH];
					res_sec    = scan_c[TABLE_DEPTH].sector;
					res_dir    = scan_c[TABLE_DEPTH].dir;
				end
			end
			OP_ADD: begin
				if (scan_c[TABLE_DEPTH].hit) begin
					res_status = ST_PRESENT;
				end else if (scan_c[TABLE_DEPTH].free) begin
					res_status = ST_OK;
					res_idx    = fidx_c[TABLE_DEPTH];
					wr.set     = out_load;
					wr_idx     = fidx_c[TABLE_DEPTH];
				end else begin
					res_status = ST_FULL;
				end
			end
			OP_REMOVE: begin
				if (scan_c[TABLE_DEPTH].hit) begin
					res_status = ST_OK;
					res_idx    = hidx_c[TABLE_DEPTH];
					wr.clr     = out_load;
					wr_idx     = hidx_c[TABLE_DEPTH];
				end
			end
			default: begin
				res_status = ST_NOT_FOUND;
			end
		endcase
	end

	assign res_idx_wide = 32'(res_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status;
			out_idx_q    <= res_idx_wide[IDX_OUT_W-1:0];
			out_sec_q    <= res_sec;
			out_dir_q    <= res_dir;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {1'b0, out_dir_q, out_sec_q, out_idx_q};

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("item accepted while another is in flight");

	a_full_means_all_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_status == ST_FULL) |-> (&slot_valid))
		else $error("table full reported with a free slot");

	a_add_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr.set |=> slot_valid[$past(wr_idx)])
		else $error("added slot not marked valid");

	a_remove_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr.clr |=> !slot_valid[$past(wr_idx)])
		else $error("removed slot still valid");
`endif

endmodule
